// ===== sv/tfc_pkg.sv =====
// Shared types, constants and helper functions for the transfer function compositor.
// Used by tfc_mul.sv and transfer_function_compositor.sv; depends on nothing.
package tfc_pkg;

  localparam int ACC_C_W = 18;   // colour accumulators, unsigned Q10.8
  localparam int ACC_A_W = 17;   // alpha accumulator, unsigned Q1.16

  localparam logic [ACC_C_W-1:0] ACC_C_MAX = '1;
  localparam logic [ACC_A_W-1:0] ACC_A_MAX = '1;
  localparam logic [ACC_A_W-1:0] ALPHA_ONE = 17'h10000;

  localparam logic [31:0] VALUE_LOW_RESET  = 32'd655360;
  localparam logic [31:0] VALUE_HIGH_RESET = 32'd983040;
  localparam logic [31:0] BIN_SCALE_RESET  = 32'd3355443;

  localparam logic [1:0] REG_VALUE_LOW  = 2'd0;
  localparam logic [1:0] REG_VALUE_HIGH = 2'd1;
  localparam logic [1:0] REG_BIN_SCALE  = 2'd2;

  localparam logic OP_TABLE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Request to the shared multiplier
  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  // Saturating add of a weighted colour term to a colour accumulator
  function automatic logic [ACC_C_W-1:0] sat_acc_c(input logic [ACC_C_W-1:0] acc,
                                                   input logic [ACC_C_W-1:0] add);
    logic [ACC_C_W:0] sum;
    sum = {1'b0, acc} + {1'b0, add};
    return sum[ACC_C_W] ? ACC_C_MAX : sum[ACC_C_W-1:0];
  endfunction

  // Saturating add of a weight to the alpha accumulator
  function automatic logic [ACC_A_W-1:0] sat_acc_a(input logic [ACC_A_W-1:0] acc,
                                                   input logic [ACC_A_W-1:0] add);
    logic [ACC_A_W:0] sum;
    sum = {1'b0, acc} + {1'b0, add};
    return sum[ACC_A_W] ? ACC_A_MAX : sum[ACC_A_W-1:0];
  endfunction

  // Colour accumulator to output byte: drop the fraction, clip at 255
  function automatic logic [7:0] out_byte(input logic [ACC_C_W-1:0] acc);
    logic [ACC_C_W-9:0] whole;
    whole = acc[ACC_C_W-1:8];
    return (whole > (ACC_C_W-8)'(255)) ? 8'hFF : whole[7:0];
  endfunction

endpackage

// ===== sv/transfer_function_compositor.sv =====
// Top level of the transfer function compositor: sequencer, transfer table, accumulators.
// Depends on tfc_pkg and tfc_mul.
//
// Front-to-back compositor for the samples of one ray. Each request carries either a
// table write (opcode 0, no result) or a ray sample (opcode 1). A sample is binned into
// the NUM_BINS-entry transfer table, the entry's colour and corrected opacity are blended
// into the accumulators, and the sample marked last gives one pixel. Every product goes
// through one shared 32x32 multiplier, so a sample occupies the block for a run of steps,
// shorter for the first sample of a ray, which seeds the accumulators: range check, bin
// product, table read, opacity weight, then one multiply per colour channel. in_stall is
// high meanwhile. The finished pixel sits in an output register, so the next sample is
// taken while it waits; a second pixel waits in the last step until the first has been
// taken. Table entries are undefined until written; a sample must not select an unwritten
// entry. Configuration (value_low at 0x0, value_high at 0x4, bin_scale at 0x8) must be
// written only while the block is idle; the block itself does not enforce this.
module transfer_function_compositor #(
  parameter int NUM_BINS = 256
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [7:0]         table_index,
  input  logic [7:0]         entry_red,
  input  logic [7:0]         entry_green,
  input  logic [7:0]         entry_blue,
  input  logic [15:0]        entry_opacity,
  input  logic signed [31:0] sample_value,
  input  logic               last_sample,
  // pixel channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         pixel_red,
  output logic [7:0]         pixel_green,
  output logic [7:0]         pixel_blue
);

  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int IDX_W = ((BIN_W > 8) ? BIN_W : 8) + 1;
  localparam int ACC_C_W = tfc_pkg::ACC_C_W;
  localparam int ACC_A_W = tfc_pkg::ACC_A_W;

  // sequencer codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RANGE  = 4'd1;
  localparam logic [3:0] ST_BIN    = 4'd2;
  localparam logic [3:0] ST_ADDR   = 4'd3;
  localparam logic [3:0] ST_WEIGHT = 4'd4;
  localparam logic [3:0] ST_MUL_R  = 4'd5;
  localparam logic [3:0] ST_MUL_G  = 4'd6;
  localparam logic [3:0] ST_MUL_B  = 4'd7;
  localparam logic [3:0] ST_ACC_B  = 4'd8;
  localparam logic [3:0] ST_EMIT   = 4'd9;

  logic [3:0] state, state_next;

  // configuration registers
  logic signed [31:0] value_low, value_high;
  logic [31:0]        bin_scale;
  logic               cfg_wr;

  // held request
  logic signed [31:0] sample;
  logic               last;
  logic               in_range;
  logic [31:0]        diff;

  // transfer table: {red, green, blue, opacity}
  logic [39:0] tf_mem [NUM_BINS];
  logic [39:0] ent;
  logic [IDX_W-1:0] wr_idx;
  logic [BIN_W-1:0] bin;
  logic [31:0]      prod_hi;

  // accumulators
  logic [ACC_C_W-1:0] acc_red, acc_green, acc_blue;
  logic [ACC_A_W-1:0] acc_alpha;
  logic               at_ray_start;
  logic [ACC_A_W-1:0] w, w_reg, rem;

  // selected entry, zero when the sample falls outside the mapped range
  logic [7:0]  col_r, col_g, col_b;
  logic [15:0] col_op;

  tfc_pkg::mul_req_t mul_req;
  logic [63:0]       prod;

  logic in_acc, out_acc, emit_now;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign in_stall = (state != ST_IDLE);
  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      value_low  <= tfc_pkg::VALUE_LOW_RESET;
      value_high <= tfc_pkg::VALUE_HIGH_RESET;
      bin_scale  <= tfc_pkg::BIN_SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tfc_pkg::REG_VALUE_LOW:  value_low  <= pwdata;
        tfc_pkg::REG_VALUE_HIGH: value_high <= pwdata;
        tfc_pkg::REG_BIN_SCALE:  bin_scale  <= pwdata;
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tfc_pkg::REG_VALUE_LOW:  prdata = value_low;
      tfc_pkg::REG_VALUE_HIGH: prdata = value_high;
      tfc_pkg::REG_BIN_SCALE:  prdata = bin_scale;
      default:                 prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- transfer table
  // Indices at or beyond NUM_BINS are dropped.
  assign wr_idx = IDX_W'(table_index);

  always_ff @(posedge clk) begin
    if (in_acc && opcode == tfc_pkg::OP_TABLE && wr_idx < IDX_W'(NUM_BINS)) begin
      tf_mem[wr_idx[BIN_W-1:0]] <= {entry_red, entry_green, entry_blue, entry_opacity};
    end
  end

  // Bin is the top word of (sample - value_low) * bin_scale, clipped to the last entry.
  assign prod_hi = prod[63:32];
  assign bin = (prod_hi > 32'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1) : prod_hi[BIN_W-1:0];

  always_ff @(posedge clk) begin
    if (state == ST_ADDR) begin
      ent <= tf_mem[bin];
    end
  end

  assign col_r  = in_range ? ent[39:32] : 8'd0;
  assign col_g  = in_range ? ent[31:24] : 8'd0;
  assign col_b  = in_range ? ent[23:16] : 8'd0;
  assign col_op = in_range ? ent[15:0]  : 16'd0;

  // ---------------------------------------------------------------- shared multiplier
  // Remaining transparency, and the weight it gives once multiplied by the opacity.
  assign rem = (acc_alpha >= tfc_pkg::ALPHA_ONE) ? '0 : tfc_pkg::ALPHA_ONE - acc_alpha;
  assign w   = prod[32:16];

  always_comb begin
    mul_req = '0;
    unique case (state)
      ST_BIN: begin
        mul_req.en = 1'b1;
        mul_req.a  = diff;
        mul_req.b  = bin_scale;
      end
      ST_WEIGHT: begin
        mul_req.en = ~at_ray_start;
        mul_req.a  = 32'(rem);
        mul_req.b  = 32'(col_op);
      end
      ST_MUL_R: begin
        mul_req.en = 1'b1;
        mul_req.a  = 32'(w);
        mul_req.b  = 32'(col_r);
      end
      ST_MUL_G: begin
        mul_req.en = 1'b1;
        mul_req.a  = 32'(w_reg);
        mul_req.b  = 32'(col_g);
      end
      ST_MUL_B: begin
        mul_req.en = 1'b1;
        mul_req.a  = 32'(w_reg);
        mul_req.b  = 32'(col_b);
      end
      default: ;
    endcase
  end

  tfc_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // ---------------------------------------------------------------- sequencer
  // Hold in the last step while a previous pixel still waits to be taken.
  assign emit_now = ~last | ~out_valid | ~out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc && opcode == tfc_pkg::OP_SAMPLE) state_next = ST_RANGE;
      ST_RANGE:  state_next = ST_BIN;
      ST_BIN:    state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_WEIGHT;
      ST_WEIGHT: state_next = at_ray_start ? ST_EMIT : ST_MUL_R;
      ST_MUL_R:  state_next = ST_MUL_G;
      ST_MUL_G:  state_next = ST_MUL_B;
      ST_MUL_B:  state_next = ST_ACC_B;
      ST_ACC_B:  state_next = ST_EMIT;
      ST_EMIT:   if (emit_now) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // held sample and range check
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample <= sample_value;
      last   <= last_sample;
    end
    if (state == ST_RANGE) begin
      in_range <= (value_low <= sample) && (sample <= value_high);
      diff     <= sample - value_low;
    end
    if (state == ST_MUL_R) begin
      w_reg <= w;
    end
  end

  // accumulators: seed on the first sample of a ray, blend front to back afterwards
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_red      <= '0;
      acc_green    <= '0;
      acc_blue     <= '0;
      acc_alpha    <= '0;
      at_ray_start <= 1'b1;
    end else begin
      case (state)
        ST_WEIGHT: begin
          if (at_ray_start) begin
            acc_red      <= ACC_C_W'({col_r, 8'd0});
            acc_green    <= ACC_C_W'({col_g, 8'd0});
            acc_blue     <= ACC_C_W'({col_b, 8'd0});
            acc_alpha    <= ACC_A_W'(col_op);
            at_ray_start <= 1'b0;
          end
        end
        ST_MUL_R: acc_alpha <= tfc_pkg::sat_acc_a(acc_alpha, w);
        ST_MUL_G: acc_red   <= tfc_pkg::sat_acc_c(acc_red,   prod[ACC_C_W+7:8]);
        ST_MUL_B: acc_green <= tfc_pkg::sat_acc_c(acc_green, prod[ACC_C_W+7:8]);
        ST_ACC_B: acc_blue  <= tfc_pkg::sat_acc_c(acc_blue,  prod[ACC_C_W+7:8]);
        ST_EMIT:  if (last && emit_now) at_ray_start <= 1'b1;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && last && emit_now) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && last && emit_now) begin
      pixel_red   <= tfc_pkg::out_byte(acc_red);
      pixel_green <= tfc_pkg::out_byte(acc_green);
      pixel_blue  <= tfc_pkg::out_byte(acc_blue);
    end
  end

  // ---------------------------------------------------------------- checks
  a_pixel_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("pixel raised outside the emit step");

  a_alpha_bounded: assert property (@(posedge clk) disable iff (rst)
    acc_alpha <= tfc_pkg::ALPHA_ONE)
    else $error("alpha accumulator beyond full opacity");

  a_table_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == tfc_pkg::OP_TABLE) |=> state == ST_IDLE)
    else $error("table write left the idle state");

  a_acc_quiet_in_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |=> $stable(acc_alpha) && $stable(acc_red))
    else $error("accumulator moved while idle");

endmodule

// ===== sv/tfc_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on tfc_pkg for the request struct.
module tfc_mul (
  input  logic             clk,
  input  tfc_pkg::mul_req_t req,
  output logic [63:0]      prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= {32'd0, req.a} * {32'd0, req.b};
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for transfer_function_compositor: directed requests, then random rays.
// Depends on tfc_pkg and the compositor RTL; drives the APB port, request and pixel channels.
`timescale 1ns / 100ps

module testbench;

  localparam int LUT_DEPTH = 256;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int NUM_PHASES = 6;
  localparam int HOLD_CYCLES = 200;

  // Sample values around the reset range 10.0 .. 15.0
  localparam logic [31:0] V_10 = 32'h000A_0000;
  localparam logic [31:0] V_12H = 32'h000C_8000;
  localparam logic [31:0] V_15 = 32'h000F_0000;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  table_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
    logic [15:0] entry_opacity;
    logic [31:0] sample_value;
    logic        last_sample;
  } request_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    request_t rq;
    logic     typed;
    pixel_t   px;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = 1'b0;
  logic [7:0]         table_index = '0;
  logic [7:0]         entry_red = '0;
  logic [7:0]         entry_green = '0;
  logic [7:0]         entry_blue = '0;
  logic [15:0]        entry_opacity = '0;
  logic signed [31:0] sample_value = '0;
  logic               last_sample = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         pixel_red;
  logic [7:0]         pixel_green;
  logic [7:0]         pixel_blue;

  transfer_function_compositor i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .table_index   (table_index),
    .entry_red     (entry_red),
    .entry_green   (entry_green),
    .entry_blue    (entry_blue),
    .entry_opacity (entry_opacity),
    .sample_value  (sample_value),
    .last_sample   (last_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_red     (pixel_red),
    .pixel_green   (pixel_green),
    .pixel_blue    (pixel_blue)
  );

  always #4 clk = ~clk;

  // Mirror of the block: range registers, transfer table and ray accumulators
  logic [31:0]                  cfg_low = tfc_pkg::VALUE_LOW_RESET;
  logic [31:0]                  cfg_high = tfc_pkg::VALUE_HIGH_RESET;
  logic [31:0]                  cfg_scale = tfc_pkg::BIN_SCALE_RESET;
  logic [23:0]                  colour_lut [LUT_DEPTH];
  logic [15:0]                  alpha_lut [LUT_DEPTH];
  logic [LUT_DEPTH-1:0]         lut_written = '0;
  logic [tfc_pkg::ACC_C_W-1:0]  acc_r = '0;
  logic [tfc_pkg::ACC_C_W-1:0]  acc_g = '0;
  logic [tfc_pkg::ACC_C_W-1:0]  acc_b = '0;
  logic [tfc_pkg::ACC_A_W-1:0]  acc_a = '0;
  bit                           ray_start = 1'b1;

  pixel_t pending_pixels[$];
  int     mismatches = 0;
  int     pixels_checked = 0;
  int     requests_sent = 0;
  int     table_writes = 0;
  int     samples_sent = 0;
  int     burst_left = 0;

  // Bin a sample selects, or -1 when it lies outside the mapped range
  function automatic int transfer_bin(input logic [31:0] s);
    logic [31:0] diff;
    logic [63:0] prod;
    if ($signed(s) < $signed(cfg_low) || $signed(s) > $signed(cfg_high)) return -1;
    diff = s - cfg_low;
    prod = {32'h0, diff} * {32'h0, cfg_scale};
    return (prod[63:32] > LUT_DEPTH - 1) ? LUT_DEPTH - 1 : int'(prod[63:32]);
  endfunction

  function automatic logic [tfc_pkg::ACC_C_W-1:0] blend_channel(
    input logic [tfc_pkg::ACC_C_W-1:0] acc,
    input int unsigned                 w,
    input logic [7:0]                  colour
  );
    int unsigned sum;
    sum = acc + ((w * colour) >> 8);
    return (sum > tfc_pkg::ACC_C_MAX) ? tfc_pkg::ACC_C_MAX : sum[tfc_pkg::ACC_C_W-1:0];
  endfunction

  function automatic logic [7:0] clip_byte(input logic [tfc_pkg::ACC_C_W-1:0] acc);
    return (acc[tfc_pkg::ACC_C_W-1:8] > 255) ? 8'hFF : acc[15:8];
  endfunction

  // Advance the mirror by one request; returns 1 when the request finishes a ray
  function automatic bit predict_pixel(input request_t rq, output pixel_t px);
    int          bin;
    logic [23:0] colour;
    logic [15:0] op;
    int unsigned rem;
    int unsigned w;
    int unsigned alpha_sum;
    px = '0;
    if (rq.opcode == tfc_pkg::OP_TABLE) begin
      colour_lut[rq.table_index] = {rq.entry_red, rq.entry_green, rq.entry_blue};
      alpha_lut[rq.table_index] = rq.entry_opacity;
      lut_written[rq.table_index] = 1'b1;
      return 1'b0;
    end
    colour = '0;
    op = '0;
    bin = transfer_bin(rq.sample_value);
    if (bin >= 0) begin
      colour = colour_lut[bin];
      op = alpha_lut[bin];
    end
    if (ray_start) begin
      // first sample of a ray seeds the accumulators unweighted
      acc_r = {2'b00, colour[23:16], 8'h00};
      acc_g = {2'b00, colour[15:8], 8'h00};
      acc_b = {2'b00, colour[7:0], 8'h00};
      acc_a = {1'b0, op};
      ray_start = 1'b0;
    end else begin
      rem = (acc_a >= tfc_pkg::ALPHA_ONE) ? 0 : 65536 - acc_a;
      w = (rem * op) >> 16;
      acc_r = blend_channel(acc_r, w, colour[23:16]);
      acc_g = blend_channel(acc_g, w, colour[15:8]);
      acc_b = blend_channel(acc_b, w, colour[7:0]);
      alpha_sum = acc_a + w;
      acc_a = (alpha_sum > tfc_pkg::ACC_A_MAX) ? tfc_pkg::ACC_A_MAX
                                               : alpha_sum[tfc_pkg::ACC_A_W-1:0];
    end
    if (!rq.last_sample) return 1'b0;
    px.red = clip_byte(acc_r);
    px.green = clip_byte(acc_g);
    px.blue = clip_byte(acc_b);
    ray_start = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 6))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] rand_opacity();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly inside the mapped range, with its ends and the odd value from anywhere
  function automatic logic [31:0] pick_sample();
    int          pick;
    longint      span;
    logic [63:0] off;
    pick = $urandom_range(0, 99);
    if ($signed(cfg_low) > $signed(cfg_high) || pick >= 85) return $urandom;
    if (pick < 5) return cfg_low;
    if (pick < 10) return cfg_high;
    span = longint'($signed(cfg_high)) - longint'($signed(cfg_low));
    off = {$urandom, $urandom} % (span + 1);
    return cfg_low + off[31:0];
  endfunction

  // Sample fields carry noise: the block must ignore them on a table write
  function automatic request_t random_table_write();
    request_t rq;
    rq.opcode = tfc_pkg::OP_TABLE;
    rq.table_index = 8'($urandom_range(0, 255));
    rq.entry_red = rand_byte();
    rq.entry_green = rand_byte();
    rq.entry_blue = rand_byte();
    rq.entry_opacity = rand_opacity();
    rq.sample_value = $urandom;
    rq.last_sample = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  function automatic request_t random_sample(input bit last);
    request_t rq;
    rq = random_table_write();
    rq.opcode = tfc_pkg::OP_SAMPLE;
    rq.sample_value = pick_sample();
    rq.last_sample = last;
    return rq;
  endfunction

  // Offer one request, in bursts with random gaps; record it in the mirror on acceptance.
  // A typed pixel, where given, replaces the mirror's expectation.
  task automatic send_request(input request_t rq, input bit typed, input pixel_t typed_px);
    pixel_t px;
    int     gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    opcode <= rq.opcode;
    table_index <= rq.table_index;
    entry_red <= rq.entry_red;
    entry_green <= rq.entry_green;
    entry_blue <= rq.entry_blue;
    entry_opacity <= rq.entry_opacity;
    sample_value <= rq.sample_value;
    last_sample <= rq.last_sample;
    do @(posedge clk); while (in_stall);
    burst_left--;
    requests_sent++;
    if (rq.opcode == tfc_pkg::OP_TABLE) table_writes++;
    else samples_sent++;
    if (predict_pixel(rq, px)) pending_pixels.push_back(typed ? typed_px : px);
  endtask

  // Drop valid and hold until every expected pixel is out, then let the pipe settle
  task automatic drain_pixels(input int extra);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] reg_idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      tfc_pkg::REG_VALUE_LOW:  cfg_low = value;
      tfc_pkg::REG_VALUE_HIGH: cfg_high = value;
      tfc_pkg::REG_BIN_SCALE:  cfg_scale = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Pixel receiver: stall on a changing duty cycle, with long hold-offs that fill the block
  int unsigned pixels_taken = 0;
  int unsigned next_hold_at = 30;
  int unsigned hold_left = 0;
  int unsigned pattern_left = 0;
  int unsigned stall_pct = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) pixels_taken++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (pixels_taken >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += 50;
        out_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 96);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 70;
            default: stall_pct = 95;
          endcase
        end else begin
          pattern_left--;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic void check_byte(input string field, input logic [7:0] want,
                                     input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Compare each accepted pixel with the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: pixel %0d %0d %0d with none expected", $time,
                 pixel_red, pixel_green, pixel_blue);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        check_byte("pixel_red", want.red, pixel_red);
        check_byte("pixel_green", want.green, pixel_green);
        check_byte("pixel_blue", want.blue, pixel_blue);
      end
    end
  end

  // Directed requests under the reset range 10.0 .. 15.0. Pixels typed in where obvious:
  // single-sample rays, the top edge, out-of-range samples and a fully opaque front sample.
  stim_row_t directed_rows [20] = '{
    // load bins 0, 255 and 127; sample fields are noise
    '{'{tfc_pkg::OP_TABLE, 8'd0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b1},
      1'b0, 24'h0},
    '{'{tfc_pkg::OP_TABLE, 8'd255, 8'h12, 8'h34, 8'h56, 16'h0000, 32'h8000_0000, 1'b0},
      1'b0, 24'h0},
    '{'{tfc_pkg::OP_TABLE, 8'd127, 8'hC8, 8'h64, 8'h32, 16'h8000, 32'h0000_0000, 1'b1},
      1'b0, 24'h0},
    // single-sample rays: seed colour comes straight out
    '{'{tfc_pkg::OP_SAMPLE, 8'hAA, 8'h00, 8'hFF, 8'h0F, 16'h1234, V_10, 1'b1},
      1'b1, '{8'hFF, 8'hFF, 8'hFF}},
    '{'{tfc_pkg::OP_SAMPLE, 8'h55, 8'hFF, 8'h00, 8'hF0, 16'hEDCB, V_15, 1'b1},
      1'b1, '{8'h12, 8'h34, 8'h56}},
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, 32'h8000_0000, 1'b1},
      1'b1, 24'h0},
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, 32'h7FFF_FFFF, 1'b1},
      1'b1, 24'h0},
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, V_10 - 1, 1'b1},
      1'b1, 24'h0},
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, V_15 + 1, 1'b1},
      1'b1, 24'h0},
    // three-sample ray with a table rewrite in the middle
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, V_12H, 1'b0},
      1'b0, 24'h0},
    '{'{tfc_pkg::OP_TABLE, 8'd127, 8'h00, 8'hFF, 8'h00, 16'hFFFF, V_15, 1'b1},
      1'b0, 24'h0},
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, V_10, 1'b0},
      1'b0, 24'h0},
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, V_12H, 1'b1},
      1'b0, 24'h0},
    // fully opaque front sample: nothing behind it shows
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, V_10, 1'b0},
      1'b0, 24'h0},
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, V_12H, 1'b0},
      1'b0, 24'h0},
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, V_15, 1'b1},
      1'b1, '{8'hFF, 8'hFF, 8'hFF}},
    // clear front sample, bright one behind: output saturates
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, V_15, 1'b0},
      1'b0, 24'h0},
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, V_10, 1'b1},
      1'b0, 24'h0},
    // ray opening outside the range
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, 32'h8000_0000, 1'b0},
      1'b0, 24'h0},
    '{'{tfc_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0, V_12H, 1'b1},
      1'b0, 24'h0}
  };

  // Range settings per random phase; phase 0 keeps the reset values
  logic [31:0] phase_low [NUM_PHASES];
  logic [31:0] phase_high [NUM_PHASES];
  logic [31:0] phase_scale [NUM_PHASES];

  initial begin
    int       phase_items;
    int       pause_at;
    int       ray_len;
    int       bin;
    bit       paused;
    request_t rq;
    request_t fill;

    // full span with even bins, a tight span that clamps, inverted, a single point, random
    phase_low   = '{tfc_pkg::VALUE_LOW_RESET, 32'h8000_0000, 32'hFFF6_0000, 32'h0064_0000,
                    32'h8000_0000, $urandom};
    phase_high  = '{tfc_pkg::VALUE_HIGH_RESET, 32'h7FFF_FFFF, 32'h000A_0000, 32'hFF9C_0000,
                    32'h8000_0000, $urandom};
    phase_scale = '{tfc_pkg::BIN_SCALE_RESET, 32'h0000_0100, 32'hFFFF_FFFF, $urandom,
                    32'h0000_0000, $urandom};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].px);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // a request that yields no pixel may still be in flight: let it finish
      drain_pixels(24);
      if (phase != 0) begin
        write_register(tfc_pkg::REG_VALUE_LOW, phase_low[phase]);
        write_register(tfc_pkg::REG_VALUE_HIGH, phase_high[phase]);
        write_register(tfc_pkg::REG_BIN_SCALE, phase_scale[phase]);
      end
      phase_items = 0;
      paused = 1'b0;
      pause_at = $urandom_range(20, ITEMS_PER_PHASE - 10);
      while (phase_items < ITEMS_PER_PHASE) begin
        ray_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        for (int k = 0; k < ray_len; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_request(random_table_write(), 1'b0, '0);
            phase_items++;
          end
          rq = random_sample(k == ray_len - 1);
          // never let a sample read a bin that has not been loaded
          bin = transfer_bin(rq.sample_value);
          if (bin >= 0 && !lut_written[bin]) begin
            fill = random_table_write();
            fill.table_index = bin[7:0];
            send_request(fill, 1'b0, '0);
            phase_items++;
          end
          send_request(rq, 1'b0, '0);
          phase_items++;
          if (!paused && phase_items >= pause_at) begin
            drain_pixels(0);
            paused = 1'b1;
          end
        end
      end
    end

    drain_pixels(24);
    $display("Sent %0d requests (%0d table writes, %0d ray samples) over %0d range settings.",
             requests_sent, table_writes, samples_sent, NUM_PHASES);
    $display("Compared %0d pixels; %0d field mismatches.", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("transfer_function_compositor: match");
    end else begin
      $display("transfer_function_compositor: mismatch");
    end
    $finish;
  end

  // Safety net: the full run needs well under a tenth of this
  initial begin
    #2000000;
    $display("%0t: run did not complete, %0d pixels still expected", $time,
             pending_pixels.size());
    $display("transfer_function_compositor: mismatch");
    $finish;
  end

endmodule
